@@ hdl/tsti_pkg.sv @@
`default_nettype none

package tsti_pkg;

    // Letter heads: A..Z then a..z
    localparam int LETTER_COUNT = 52;
    localparam int SLOT_W       = 6;
    localparam int SYM_W        = 8;

    // Character codes
    localparam logic [SYM_W-1:0] END_MARK  = 8'h2A;
    localparam logic [SYM_W-1:0] UPPER_A   = 8'h41;
    localparam logic [SYM_W-1:0] UPPER_Z   = 8'h5A;
    localparam logic [SYM_W-1:0] LOWER_A   = 8'h61;
    localparam logic [SYM_W-1:0] LOWER_Z   = 8'h7A;
    localparam logic [SYM_W-1:0] LOWER_GAP = 8'd6;

    // Opcode of an input beat
    localparam logic OP_END = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_PRESENT  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_BADFIRST = 2'd3;

    // Walk modes of the current word
    localparam logic [1:0] MODE_FIRST   = 2'd0;
    localparam logic [1:0] MODE_MATCH   = 2'd1;
    localparam logic [1:0] MODE_APPEND  = 2'd2;
    localparam logic [1:0] MODE_DISCARD = 2'd3;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Classified item
    typedef struct packed {
        logic              is_end;
        logic [SYM_W-1:0]  sym;
        logic              slot_ok;
        logic [SLOT_W-1:0] slot;
    } item_t;

    // Head of the queue as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } qbeat_t;

endpackage

`default_nettype wire

@@ hdl/tsti_ram.sv @@
`default_nettype none

module tsti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/tsti_front.sv @@
`default_nettype none

module tsti_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         opcode,
    input  logic [tsti_pkg::SYM_W-1:0]   char_code,
    output logic                         push_valid,
    output tsti_pkg::item_t              push_item,
    input  logic                         push_full
);

    logic                         valid_reg;
    logic                         valid_next;
    tsti_pkg::item_t              item_reg;
    tsti_pkg::item_t              item_cls;
    logic                         is_upper;
    logic                         is_lower;
    logic [tsti_pkg::SYM_W-1:0]   ofs;
    logic                         load;
    logic                         accept;

    // Classify the incoming beat: end mark, letter slot
    always_comb
    begin
        is_upper = (char_code >= tsti_pkg::UPPER_A) && (char_code <= tsti_pkg::UPPER_Z);
        is_lower = (char_code >= tsti_pkg::LOWER_A) && (char_code <= tsti_pkg::LOWER_Z);
        ofs      = char_code - tsti_pkg::UPPER_A;
        item_cls.is_end  = (opcode == tsti_pkg::OP_END);
        item_cls.sym     = item_cls.is_end ? tsti_pkg::END_MARK : char_code;
        item_cls.slot_ok = is_upper || is_lower;
        item_cls.slot    = is_upper ? tsti_pkg::SLOT_W'(ofs)
                                    : tsti_pkg::SLOT_W'(ofs - tsti_pkg::LOWER_GAP);
    end

    // Take a new beat whenever the holding register is empty or drains
    assign load       = !valid_reg || !push_full;
    assign in_stall   = !load;
    assign accept     = in_valid && load;
    assign valid_next = load ? in_valid : valid_reg;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the classified beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_cls;
        end
    end

endmodule

`default_nettype wire

@@ hdl/tsti_queue.sv @@
`default_nettype none

module tsti_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  tsti_pkg::item_t   push_item,
    output logic              push_full,
    output tsti_pkg::qbeat_t  q_beat,
    input  logic              pop
);

    tsti_pkg::item_t                 slot_reg [tsti_pkg::QUEUE_DEPTH];
    logic [tsti_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [tsti_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [tsti_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [tsti_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [tsti_pkg::QCNT_W-1:0]     count_reg;
    logic [tsti_pkg::QCNT_W-1:0]     count_next;
    logic                            do_push;
    logic                            do_pop;

    assign push_full    = (count_reg == tsti_pkg::QCNT_W'(tsti_pkg::QUEUE_DEPTH));
    assign do_push      = push_valid && !push_full;
    assign do_pop       = pop && (count_reg != '0);
    assign q_beat.valid = (count_reg != '0);
    assign q_beat.item  = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap, track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == tsti_pkg::QPTR_W'(tsti_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + tsti_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == tsti_pkg::QPTR_W'(tsti_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + tsti_pkg::QPTR_W'(1);
        end
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + tsti_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - tsti_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ hdl/tsti_back.sv @@
`default_nettype none

module tsti_back #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tsti_pkg::qbeat_t                     q_beat,
    output logic                                 q_pop,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           status,
    output logic [$clog2(TABLE_DEPTH)-1:0]       marker_index,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]     used_entries
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = AW + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_HEAD   = 3'd2;
    localparam logic [2:0] S_WALK   = 3'd3;
    localparam logic [2:0] S_CMP    = 3'd4;
    localparam logic [2:0] S_APPEND = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    localparam logic [LW-1:0] LINK_NULL = '1;

    logic [2:0]                            state_reg;
    logic [2:0]                            state_next;
    logic [1:0]                            mode_reg;
    logic [1:0]                            mode_next;
    logic [1:0]                            pend_reg;
    logic [1:0]                            pend_next;
    logic [CW-1:0]                         fill_reg;
    logic [CW-1:0]                         fill_next;
    logic [CW-1:0]                         cursor_reg;
    logic [CW-1:0]                         cursor_next;
    logic [tsti_pkg::LETTER_COUNT-1:0]     head_valid_reg;
    logic [tsti_pkg::LETTER_COUNT-1:0]     head_valid_next;
    tsti_pkg::item_t                       item_reg;
    tsti_pkg::item_t                       item_next;
    logic [1:0]                            st_reg;
    logic [1:0]                            st_next;
    logic [AW-1:0]                         pos_reg;
    logic [AW-1:0]                         pos_next;
    logic                                  res_valid_reg;
    logic                                  res_valid_next;
    logic [1:0]                            res_status_reg;
    logic [1:0]                            res_status_next;
    logic [AW-1:0]                         res_marker_reg;
    logic [AW-1:0]                         res_marker_next;
    logic [CW-1:0]                         res_used_reg;
    logic [CW-1:0]                         res_used_next;

    logic                                  sym_we;
    logic [AW-1:0]                         sym_waddr;
    logic [tsti_pkg::SYM_W-1:0]            sym_rdata;
    logic                                  link_we;
    logic [AW-1:0]                         link_waddr;
    logic [LW-1:0]                         link_wdata;
    logic [LW-1:0]                         link_rdata;
    logic                                  head_we;
    logic [AW-1:0]                         head_rdata;

    logic                                  table_full;
    logic                                  out_free;
    logic                                  found;

    // Symbol store: written only at the fill point, so entries below fill are valid
    tsti_ram #(
        .WIDTH (tsti_pkg::SYM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_sym_ram (
        .clk   (clk),
        .we    (sym_we),
        .waddr (sym_waddr),
        .wdata (item_reg.sym),
        .raddr (cursor_reg[AW-1:0]),
        .rdata (sym_rdata)
    );

    // Next links: top bit set marks no link; cleared on append
    tsti_ram #(
        .WIDTH (LW),
        .DEPTH (TABLE_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (cursor_reg[AW-1:0]),
        .rdata (link_rdata)
    );

    // Letter heads, qualified by head_valid_reg
    tsti_ram #(
        .WIDTH (AW),
        .DEPTH (tsti_pkg::LETTER_COUNT)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (item_reg.slot),
        .wdata (fill_reg[AW-1:0]),
        .raddr (item_reg.slot),
        .rdata (head_rdata)
    );

    assign table_full = (fill_reg >= CW'(TABLE_DEPTH));
    assign out_free   = !res_valid_reg || !out_stall;
    assign found      = (sym_rdata == item_reg.sym);

    // Sequence one item: classify by mode, walk links, append, report
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        pend_next       = pend_reg;
        fill_next       = fill_reg;
        cursor_next     = cursor_reg;
        head_valid_next = head_valid_reg;
        item_next       = item_reg;
        st_next         = st_reg;
        pos_next        = pos_reg;
        res_valid_next  = res_valid_reg && out_stall;
        res_status_next = res_status_reg;
        res_marker_next = res_marker_reg;
        res_used_next   = res_used_reg;
        q_pop           = 1'b0;
        sym_we          = 1'b0;
        sym_waddr       = fill_reg[AW-1:0];
        link_we         = 1'b0;
        link_waddr      = fill_reg[AW-1:0];
        link_wdata      = LINK_NULL;
        head_we         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_beat.valid)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_beat.item;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (!item_reg.is_end)
                begin
                    unique case (mode_reg)
                        tsti_pkg::MODE_DISCARD:
                        begin
                            state_next = S_IDLE;
                        end
                        tsti_pkg::MODE_FIRST:
                        begin
                            if (!item_reg.slot_ok)
                            begin
                                pend_next  = tsti_pkg::ST_BADFIRST;
                                mode_next  = tsti_pkg::MODE_DISCARD;
                                state_next = S_IDLE;
                            end
                            else if (!head_valid_reg[item_reg.slot])
                            begin
                                if (table_full)
                                begin
                                    pend_next = tsti_pkg::ST_FULL;
                                    mode_next = tsti_pkg::MODE_DISCARD;
                                end
                                else
                                begin
                                    head_we                         = 1'b1;
                                    head_valid_next[item_reg.slot]  = 1'b1;
                                    cursor_next                     = fill_reg;
                                    mode_next                       = tsti_pkg::MODE_APPEND;
                                end
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                state_next = S_HEAD;
                            end
                        end
                        tsti_pkg::MODE_APPEND:
                        begin
                            state_next = S_APPEND;
                        end
                        tsti_pkg::MODE_MATCH:
                        begin
                            state_next = S_WALK;
                        end
                    endcase
                end
                else
                begin
                    unique case (mode_reg)
                        tsti_pkg::MODE_FIRST:
                        begin
                            st_next    = tsti_pkg::ST_BADFIRST;
                            state_next = S_DONE;
                        end
                        tsti_pkg::MODE_DISCARD:
                        begin
                            st_next    = (pend_reg == tsti_pkg::ST_FULL)
                                         ? tsti_pkg::ST_FULL : tsti_pkg::ST_BADFIRST;
                            state_next = S_DONE;
                        end
                        tsti_pkg::MODE_APPEND:
                        begin
                            state_next = S_APPEND;
                        end
                        tsti_pkg::MODE_MATCH:
                        begin
                            state_next = S_WALK;
                        end
                    endcase
                end
            end

            S_HEAD:
            begin
                cursor_next = CW'(head_rdata);
                mode_next   = tsti_pkg::MODE_MATCH;
                state_next  = S_IDLE;
            end

            S_WALK:
            begin
                // Walking onto the fill point turns into appending
                if (cursor_reg >= fill_reg)
                begin
                    mode_next  = tsti_pkg::MODE_APPEND;
                    state_next = S_APPEND;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end

            S_CMP:
            begin
                if (found)
                begin
                    if (item_reg.is_end)
                    begin
                        st_next    = tsti_pkg::ST_PRESENT;
                        pos_next   = cursor_reg[AW-1:0];
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cursor_next = cursor_reg + CW'(1);
                        state_next  = S_IDLE;
                    end
                end
                else if (!link_rdata[AW])
                begin
                    cursor_next = CW'(link_rdata[AW-1:0]);
                    state_next  = S_WALK;
                end
                else if (table_full)
                begin
                    if (item_reg.is_end)
                    begin
                        st_next    = tsti_pkg::ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pend_next  = tsti_pkg::ST_FULL;
                        mode_next  = tsti_pkg::MODE_DISCARD;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    // Hang a new branch off this entry at the fill point
                    link_we     = 1'b1;
                    link_waddr  = cursor_reg[AW-1:0];
                    link_wdata  = {1'b0, fill_reg[AW-1:0]};
                    cursor_next = fill_reg;
                    mode_next   = tsti_pkg::MODE_APPEND;
                    state_next  = S_APPEND;
                end
            end

            S_APPEND:
            begin
                if (table_full)
                begin
                    if (item_reg.is_end)
                    begin
                        st_next    = tsti_pkg::ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pend_next  = tsti_pkg::ST_FULL;
                        mode_next  = tsti_pkg::MODE_DISCARD;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    sym_we      = 1'b1;
                    link_we     = 1'b1;
                    pos_next    = fill_reg[AW-1:0];
                    fill_next   = fill_reg + CW'(1);
                    cursor_next = fill_reg + CW'(1);
                    if (item_reg.is_end)
                    begin
                        st_next    = tsti_pkg::ST_INSERTED;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_DONE:
            begin
                // Load the result beat once the output register frees up
                if (out_free)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = st_reg;
                    res_marker_next = ((st_reg == tsti_pkg::ST_INSERTED) ||
                                       (st_reg == tsti_pkg::ST_PRESENT)) ? pos_reg : '0;
                    res_used_next   = fill_reg;
                    mode_next       = tsti_pkg::MODE_FIRST;
                    pend_next       = 2'd0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= tsti_pkg::MODE_FIRST;
            pend_reg       <= 2'd0;
            fill_reg       <= '0;
            cursor_reg     <= '0;
            head_valid_reg <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            pend_reg       <= pend_next;
            fill_reg       <= fill_next;
            cursor_reg     <= cursor_next;
            head_valid_reg <= head_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        st_reg         <= st_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_marker_reg <= res_marker_next;
        res_used_reg   <= res_used_next;
    end

    assign out_valid    = res_valid_reg;
    assign status       = res_status_reg;
    assign marker_index = res_marker_reg;
    assign used_entries = res_used_reg;

endmodule

`default_nettype wire

@@ hdl/trie_symbol_table_insert_core.sv @@
// Results: an end beat gives one result; character beats give no result.
// Flow: the back-end sequencer works on one beat at a time, stepping through its states,
//   the followed next links and the registered store reads, while the front register and
//   the queue take new beats meanwhile; a stalled result holds the sequencer.
// Reset: head valid bits, fill count and control clear at once; no clearing pass.
`default_nettype none

module trie_symbol_table_insert_core #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 opcode,
    input  logic [7:0]                           char_code,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           status,
    output logic [$clog2(TABLE_DEPTH)-1:0]       marker_index,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]     used_entries
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic               push_valid;
    tsti_pkg::item_t    push_item;
    logic               push_full;
    tsti_pkg::qbeat_t   q_beat;
    logic               q_pop;

    // Accept and classify beats
    tsti_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .char_code  (char_code),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_full  (push_full)
    );

    // Decouple front and back
    tsti_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_full  (push_full),
        .q_beat     (q_beat),
        .pop        (q_pop)
    );

    // Walk and grow the trie
    tsti_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_beat       (q_beat),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .marker_index (marker_index),
        .used_entries (used_entries)
    );

    // Fill count never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (used_entries <= CW'(TABLE_DEPTH)))
        else $error("used_entries beyond table depth");

    // A fresh insert puts its marker in the last filled entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == tsti_pkg::ST_INSERTED))
        |-> (used_entries == CW'(marker_index) + CW'(1)))
        else $error("inserted marker not at last filled entry");

    // A found word points inside the filled part of the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == tsti_pkg::ST_PRESENT))
        |-> (CW'(marker_index) < used_entries))
        else $error("present marker outside filled entries");

    // Error results carry no marker position
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((status == tsti_pkg::ST_FULL) || (status == tsti_pkg::ST_BADFIRST)))
        |-> (marker_index == '0))
        else $error("error result with nonzero marker index");

endmodule

`default_nettype wire

@@ sim/tb_trie_symbol_table_insert_core.sv @@
`default_nettype none

module tb_trie_symbol_table_insert_core;

    localparam int DEPTH       = 1024;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int NO_LINK     = -1;
    localparam int BANK_SIZE   = 48;
    localparam int MAX_LEN     = 48;
    localparam int RANDOM_BEATS = 600;
    localparam int HOLD_CYCLES = 200;
    localparam int HOLD_AT     = 500;
    localparam int STALL_LIMIT = 3000;

    localparam logic       OP_CHAR  = ~tsti_pkg::OP_END;
    localparam logic [1:0] NO_ERROR = 2'd0;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] marker;
        logic [CNT_W-1:0] used;
    } result_t;

    typedef struct packed {
        logic       op;
        logic [7:0] ch;
        logic       pause;
        logic       has_res;
        result_t    res;
    } beat_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    logic             opcode    = 1'b0;
    logic [7:0]       char_code = 8'd0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [1:0]       status;
    logic [IDX_W-1:0] marker_index;
    logic [CNT_W-1:0] used_entries;

    trie_symbol_table_insert_core #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .char_code   (char_code),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .marker_index(marker_index),
        .used_entries(used_entries)
    );

    // Shadow trie: heads, symbols, links and walk state
    int                         head_ptr [tsti_pkg::LETTER_COUNT];
    logic [tsti_pkg::SYM_W-1:0] sym_mem  [DEPTH];
    int                         link_mem [DEPTH];
    int                         fill_ctr;
    int                         walk_pos;
    logic [1:0]                 walk_state;
    logic [1:0]                 held_error;

    beat_t   pending_beats[$];
    result_t expected_results[$];
    beat_t   cur_beat;
    bit      pause_next;
    bit      stim_done;
    int      beats_sent;
    int      error_count;
    int      idle_cycles;
    int      hold_left;
    bit      hold_done;
    int      status_count [4];

    // Word scratch and a bank of earlier words for repeats
    logic [7:0] word_buf   [MAX_LEN];
    int         word_len;
    logic [7:0] bank_chars [BANK_SIZE][MAX_LEN];
    int         bank_len   [BANK_SIZE];
    int         bank_count;

    always #5 clk = ~clk;

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic int letter_index(input logic [7:0] c);
        if (c >= tsti_pkg::UPPER_A && c <= tsti_pkg::UPPER_Z)
            return int'(c - tsti_pkg::UPPER_A);
        if (c >= tsti_pkg::LOWER_A && c <= tsti_pkg::LOWER_Z)
            return int'(c - tsti_pkg::UPPER_A - tsti_pkg::LOWER_GAP);
        return -1;
    endfunction

    task automatic clear_trie();
        int i;
        for (i = 0; i < tsti_pkg::LETTER_COUNT; i++)
            head_ptr[i] = NO_LINK;
        for (i = 0; i < DEPTH; i++)
        begin
            sym_mem[i]  = 8'd32;
            link_mem[i] = NO_LINK;
        end
        fill_ctr   = 0;
        walk_pos   = 0;
        walk_state = tsti_pkg::MODE_FIRST;
        held_error = NO_ERROR;
    endtask

    // Match or append one symbol; going stays set while the word may continue
    task automatic place_symbol(input logic [7:0] s, input bit is_end, output bit going,
                                output logic [1:0] st, output int pos);
        int g;
        int lk;
        going = 1'b0;
        st    = tsti_pkg::ST_FULL;
        pos   = 0;
        if (walk_state == tsti_pkg::MODE_MATCH)
        begin
            for (g = 0; g <= DEPTH; g++)
            begin
                if (walk_pos >= fill_ctr)
                begin
                    walk_state = tsti_pkg::MODE_APPEND;
                    break;
                end
                if (sym_mem[walk_pos] == s)
                begin
                    if (is_end)
                    begin
                        pos = walk_pos;
                        st  = tsti_pkg::ST_PRESENT;
                        return;
                    end
                    walk_pos++;
                    going = 1'b1;
                    return;
                end
                lk = link_mem[walk_pos];
                if (lk >= 0 && lk < DEPTH)
                begin
                    walk_pos = lk;
                    continue;
                end
                if (fill_ctr >= DEPTH)
                    return;
                // Branch off to the fill point
                link_mem[walk_pos] = fill_ctr;
                walk_pos   = fill_ctr;
                walk_state = tsti_pkg::MODE_APPEND;
                break;
            end
            if (walk_state != tsti_pkg::MODE_APPEND)
                return;
        end
        if (fill_ctr >= DEPTH)
            return;
        pos               = fill_ctr;
        sym_mem[fill_ctr] = s;
        fill_ctr++;
        walk_pos = fill_ctr;
        if (is_end)
            st = tsti_pkg::ST_INSERTED;
        else
            going = 1'b1;
    endtask

    // Advance the shadow trie by one beat and produce the expected result
    task automatic predict_beat(input logic op, input logic [7:0] ch, output logic has_res,
                                output result_t res);
        int         slot;
        bit         going;
        logic [1:0] st;
        int         pos;
        has_res = 1'b0;
        res     = '0;
        pos     = 0;
        st      = tsti_pkg::ST_BADFIRST;
        if (op == OP_CHAR)
        begin
            if (walk_state == tsti_pkg::MODE_DISCARD)
                return;
            if (walk_state == tsti_pkg::MODE_FIRST)
            begin
                slot = letter_index(ch);
                if (slot < 0)
                begin
                    held_error = tsti_pkg::ST_BADFIRST;
                    walk_state = tsti_pkg::MODE_DISCARD;
                end
                else if (head_ptr[slot] == NO_LINK)
                begin
                    if (fill_ctr >= DEPTH)
                    begin
                        held_error = tsti_pkg::ST_FULL;
                        walk_state = tsti_pkg::MODE_DISCARD;
                    end
                    else
                    begin
                        head_ptr[slot] = fill_ctr;
                        walk_pos       = fill_ctr;
                        walk_state     = tsti_pkg::MODE_APPEND;
                    end
                end
                else
                begin
                    walk_pos   = head_ptr[slot];
                    walk_state = tsti_pkg::MODE_MATCH;
                end
                return;
            end
            place_symbol(ch, 1'b0, going, st, pos);
            if (!going)
            begin
                held_error = tsti_pkg::ST_FULL;
                walk_state = tsti_pkg::MODE_DISCARD;
            end
            return;
        end
        if (walk_state == tsti_pkg::MODE_FIRST)
            st = tsti_pkg::ST_BADFIRST;
        else if (walk_state == tsti_pkg::MODE_DISCARD)
            st = (held_error == tsti_pkg::ST_FULL) ? tsti_pkg::ST_FULL : tsti_pkg::ST_BADFIRST;
        else
            place_symbol(tsti_pkg::END_MARK, 1'b1, going, st, pos);
        if (st != tsti_pkg::ST_INSERTED && st != tsti_pkg::ST_PRESENT)
            pos = 0;
        walk_state = tsti_pkg::MODE_FIRST;
        held_error = NO_ERROR;
        has_res    = 1'b1;
        res.status = st;
        res.marker = pos[IDX_W-1:0];
        res.used   = fill_ctr[CNT_W-1:0];
    endtask

    task automatic add_beat(input logic op, input logic [7:0] ch);
        beat_t b;
        b.op    = op;
        b.ch    = ch;
        b.pause = pause_next;
        predict_beat(op, ch, b.has_res, b.res);
        pause_next = 1'b0;
        pending_beats.push_back(b);
    endtask

    task automatic add_text(input string w);
        int i;
        for (i = 0; i < w.len(); i++)
            add_beat(OP_CHAR, w[i]);
        add_beat(tsti_pkg::OP_END, 8'($urandom_range(255)));
    endtask

    task automatic emit_word();
        int i;
        for (i = 0; i < word_len; i++)
            add_beat(OP_CHAR, word_buf[i]);
        add_beat(tsti_pkg::OP_END, 8'($urandom_range(255)));
    endtask

    task automatic save_word();
        int i;
        if (bank_count < BANK_SIZE)
        begin
            for (i = 0; i < word_len; i++)
                bank_chars[bank_count][i] = word_buf[i];
            bank_len[bank_count] = word_len;
            bank_count++;
        end
    endtask

    task automatic load_word(input int k);
        int i;
        word_len = bank_len[k];
        for (i = 0; i < word_len; i++)
            word_buf[i] = bank_chars[k][i];
    endtask

    // Few leading letters so that words share heads and prefixes
    function automatic logic [7:0] lead_letter();
        unique case ($urandom_range(5))
            0:       return "A";
            1:       return "B";
            2:       return "Z";
            3:       return "a";
            4:       return "b";
            default: return "z";
        endcase
    endfunction

    function automatic logic [7:0] tail_letter();
        unique case ($urandom_range(7))
            0:       return "a";
            1:       return "b";
            2:       return "c";
            3:       return "A";
            4:       return "B";
            5:       return tsti_pkg::END_MARK;
            6:       return "z";
            default: return "Z";
        endcase
    endfunction

    task automatic random_word();
        int         r;
        int         i;
        int         n;
        logic [7:0] c;
        r = $urandom_range(99);
        if (r < 40 && bank_count > 0)
            load_word($urandom_range(bank_count - 1));
        else if (r < 55 && bank_count > 0)
        begin
            // Cut a known word short, then grow a new tail on it
            load_word($urandom_range(bank_count - 1));
            word_len = $urandom_range(word_len, 1);
            n = $urandom_range(3);
            for (i = 0; i < n; i++)
            begin
                word_buf[word_len] = tail_letter();
                word_len++;
            end
        end
        else if (r < 80)
        begin
            word_len    = $urandom_range(6, 1);
            word_buf[0] = lead_letter();
            for (i = 1; i < word_len; i++)
                word_buf[i] = tail_letter();
            save_word();
        end
        else if (r < 87)
        begin
            do
                c = 8'($urandom_range(255));
            while (letter_index(c) >= 0);
            word_len    = $urandom_range(4, 1);
            word_buf[0] = c;
            for (i = 1; i < word_len; i++)
                word_buf[i] = 8'($urandom_range(255));
        end
        else if (r < 92)
            word_len = 0;
        else
        begin
            word_len    = $urandom_range(5, 2);
            word_buf[0] = lead_letter();
            for (i = 1; i < word_len; i++)
                word_buf[i] = 8'($urandom_range(255));
        end
        emit_word();
    endtask

    // Build the whole beat list with its expected results
    initial
    begin : build_stimulus
        int target;
        clear_trie();
        pause_next = 1'b0;
        bank_count = 0;

        // Directed: first and last letters, repeats, side branch, empty word,
        // bad first bytes at both ends and next to the letter ranges, star in a word
        add_text("A");
        add_text("A");
        add_text("z");
        add_text("Ab");
        add_text("Ab");
        add_beat(tsti_pkg::OP_END, 8'h00);
        add_beat(OP_CHAR, 8'h00);
        add_beat(OP_CHAR, "x");
        add_beat(tsti_pkg::OP_END, 8'hFF);
        add_beat(OP_CHAR, 8'hFF);
        add_beat(tsti_pkg::OP_END, 8'h00);
        add_text("z*");
        add_text("@");
        add_text("{");

        // Random short words over a small alphabet
        pause_next = 1'b1;
        target = pending_beats.size() + RANDOM_BEATS;
        while (pending_beats.size() < target)
            random_word();

        // Closing words: new heads, branches off known heads, repeats, error words
        pause_next = 1'b1;
        add_text("Q");
        add_text("qab");
        add_text("Ab");
        add_text("AzqQzq");
        add_text("A");
        add_beat(tsti_pkg::OP_END, 8'h55);
        add_text("#x");
        load_word(0);
        emit_word();
    end

    function automatic int idle_phase();
        if (beats_sent < 220)
            return 0;
        if (beats_sent < 440)
            return 1;
        return 2;
    endfunction

    function automatic bit roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // Drive input beats from the pending list
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            opcode    <= 1'b0;
            char_code <= 8'd0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (cur_beat.has_res)
                    expected_results.push_back(cur_beat.res);
                beats_sent++;
                if (pending_beats.size() == 0)
                    stim_done = 1'b1;
            end
            // Hold a stalled beat; otherwise offer the next one or idle
            if (!(in_valid && in_stall))
            begin
                if (pending_beats.size() != 0
                    && !roll(idle_phase() == 0 ? 7 : idle_phase() == 1 ? 72 : 0)
                    && !(pending_beats[0].pause && expected_results.size() != 0))
                begin
                    cur_beat  = pending_beats.pop_front();
                    in_valid  <= 1'b1;
                    opcode    <= cur_beat.op;
                    char_code <= cur_beat.ch;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(input string what, input int exp_v, input int act_v);
        if (error_count < 100)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
        error_count++;
    endtask

    // Check result beats and drive the output stall
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        result_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                status_count[status]++;
                if (expected_results.size() == 0)
                begin
                    if (error_count < 100)
                        $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d",
                                 $time, status, marker_index, used_entries);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", want.status, status);
                    if (marker_index !== want.marker)
                        report_mismatch("marker_index", want.marker, marker_index);
                    if (used_entries !== want.used)
                        report_mismatch("used_entries", want.used, used_entries);
                end
            end
            // One long hold-off so the block backs up into its input
            if (!hold_done && beats_sent >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= roll(idle_phase() == 0 ? 72 : idle_phase() == 1 ? 7 : 0);
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        while (!stim_done || expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("Sent %0d beats; results: %0d inserted, %0d present, %0d full, %0d bad first",
                 beats_sent, status_count[tsti_pkg::ST_INSERTED],
                 status_count[tsti_pkg::ST_PRESENT], status_count[tsti_pkg::ST_FULL],
                 status_count[tsti_pkg::ST_BADFIRST]);
        $display("Table grown to %0d of %0d entries, with idle mixes, a long hold-off and a drain",
                 fill_ctr, DEPTH);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
hdl/tsti_pkg.sv
hdl/tsti_ram.sv
hdl/tsti_front.sv
hdl/tsti_queue.sv
hdl/tsti_back.sv
hdl/trie_symbol_table_insert_core.sv
sim/tb_trie_symbol_table_insert_core.sv
